// File: sv/lqml_pkg.sv
// shared types, constants and index helpers for the quadtree merge and locate block
package lqml_pkg;

  localparam int LEVEL_LIMIT  = 4;
  localparam int IMAGE_WIDTH  = 640;
  localparam int IMAGE_HEIGHT = 480;
  localparam int NODE_COUNT   = ((1 << (2 * (LEVEL_LIMIT + 1))) - 1) / 3;

  localparam int ACT_W = 2;
  localparam int IDX_W = 9;
  localparam int VAL_W = 9;
  localparam int DEP_W = 3;
  localparam int CRD_W = 4;
  localparam int PIX_W = 12;
  localparam int MID_W = PIX_W + CRD_W;

  localparam logic [VAL_W-1:0] SPLIT_MARK = '1;
  localparam logic [DEP_W-1:0] DEPTH_LAST = DEP_W'(LEVEL_LIMIT);
  localparam logic [PIX_W-1:0] IMG_W      = PIX_W'(IMAGE_WIDTH);
  localparam logic [PIX_W-1:0] IMG_H      = PIX_W'(IMAGE_HEIGHT);

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_MERGE  = 2'd1,
    ACT_LOCATE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WCHK,
    ST_LOC,
    ST_MRD,
    ST_MCHK,
    ST_MWR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [DEP_W-1:0] depth;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             dirty;
  } result_t;

  function automatic logic [IDX_W-1:0] lin_index(input logic [DEP_W-1:0] depth,
                                                 input logic [CRD_W-1:0] x,
                                                 input logic [CRD_W-1:0] y);
    logic [IDX_W-1:0] base;
    base = '0;
    for (int i = 0; i <= LEVEL_LIMIT; i++) begin
      if (DEP_W'(i) < depth) begin
        base = base + (IDX_W'(1) << (2 * i));
      end
    end
    return base + (IDX_W'(y) << depth) + IDX_W'(x);
  endfunction

  function automatic logic [MID_W-1:0] midpoint(input logic [DEP_W-1:0] depth,
                                                input logic [CRD_W-1:0] c,
                                                input logic [PIX_W-1:0] size);
    logic [PIX_W-1:0] w;
    w = size >> depth;
    return MID_W'(c) * MID_W'(w) + MID_W'(w >> 1);
  endfunction

endpackage

// File: sv/lqml_node_ram.sv
// node store: one write port, one read port with registered read data
module lqml_node_ram #(
  parameter int DEPTH = 341,
  parameter int WIDTH = 9,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// File: sv/lqml_ctrl.sv
// sequencer for write, merge sweep and locate walk over the node store
module lqml_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [lqml_pkg::ACT_W-1:0] action_i,
  input  logic [lqml_pkg::IDX_W-1:0] node_index_i,
  input  logic [lqml_pkg::VAL_W-1:0] node_value_i,
  input  logic [lqml_pkg::PIX_W-1:0] pixel_x_i,
  input  logic [lqml_pkg::PIX_W-1:0] pixel_y_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output lqml_pkg::result_t        res_o
);
  import lqml_pkg::*;

  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] val_q, val_d, v1_q, v1_d;
  logic [PIX_W-1:0] px_q, px_d, py_q, py_d;
  logic [DEP_W-1:0] dep_q, dep_d;
  logic [CRD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [1:0]       cc_q, cc_d;
  logic [2:0]       wc_q, wc_d;
  logic             dirty_q, dirty_d;
  result_t          res_q, res_d;

  logic             accept;
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data, rd_data;
  logic [DEP_W-1:0] nd;
  logic [CRD_W-1:0] nx, ny, side_last;
  logic             loc_stop, chk_fail, grid_end;
  logic [1:0]       wchild;

  lqml_node_ram #(.DEPTH(NODE_COUNT), .WIDTH(VAL_W), .AW(IDX_W)) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o      = res_q;

  assign nd       = dep_q + DEP_W'(1);
  assign nx       = {cx_q[CRD_W-2:0], ({4'd0, px_q} >= midpoint(dep_q, cx_q, IMG_W))};
  assign ny       = {cy_q[CRD_W-2:0], ({4'd0, py_q} >= midpoint(dep_q, cy_q, IMG_H))};
  assign loc_stop = (rd_data != SPLIT_MARK) || (nd == DEPTH_LAST);
  assign chk_fail = (cc_q == 2'd0) ? (rd_data == SPLIT_MARK) : (rd_data != v1_q);
  assign side_last = CRD_W'((1 << dep_q) - 1);
  assign grid_end = (cx_q == side_last) && (cy_q == side_last) && (dep_q == '0);
  assign wchild   = 2'(wc_q - 3'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_WRITE:  state_d = ST_WCHK;
            ACT_MERGE:  state_d = ST_MRD;
            ACT_LOCATE: state_d = (pixel_x_i >= IMG_W || pixel_y_i >= IMG_H) ? ST_DONE : ST_LOC;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_WCHK: state_d = ST_DONE;
      ST_LOC:  state_d = loc_stop ? ST_DONE : ST_LOC;
      ST_MRD:  state_d = ST_MCHK;
      ST_MCHK: begin
        if (chk_fail) begin
          state_d = grid_end ? ST_DONE : ST_MRD;
        end else if (cc_q == 2'd3) begin
          state_d = ST_MWR;
        end
      end
      ST_MWR: begin
        if (wc_q == 3'd4) begin
          state_d = grid_end ? ST_DONE : ST_MRD;
        end
      end
      ST_DONE: state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    idx_d   = idx_q;
    val_d   = val_q;
    v1_d    = v1_q;
    px_d    = px_q;
    py_d    = py_q;
    dep_d   = dep_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cc_d    = cc_q;
    wc_d    = wc_q;
    dirty_d = dirty_q;
    res_d   = res_q;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d = node_index_i;
          val_d = node_value_i;
          px_d  = pixel_x_i;
          py_d  = pixel_y_i;
          dep_d = '0;
          cx_d  = '0;
          cy_d  = '0;
          cc_d  = '0;
          wc_d  = '0;
          res_d = '0;
          res_d.dirty = dirty_q;
          if (action_e'(action_i) == ACT_WRITE) begin
            rd_en   = (node_index_i < IDX_W'(NODE_COUNT));
            rd_addr = node_index_i;
          end else if (action_e'(action_i) == ACT_MERGE) begin
            dep_d = DEP_W'(LEVEL_LIMIT - 1);
          end else if (action_e'(action_i) == ACT_LOCATE) begin
            rd_en   = 1'b1;
            rd_addr = '0;
          end
        end
      end
      ST_WCHK: begin
        if (idx_q < IDX_W'(NODE_COUNT) && rd_data != val_q) begin
          wr_en   = 1'b1;
          wr_addr = idx_q;
          wr_data = val_q;
          dirty_d = 1'b1;
        end
        res_d.dirty = dirty_d;
      end
      ST_LOC: begin
        if (rd_data != SPLIT_MARK) begin
          res_d.index = lin_index(dep_q, cx_q, cy_q);
          res_d.depth = dep_q;
          res_d.x     = cx_q;
          res_d.y     = cy_q;
        end else begin
          dep_d = nd;
          cx_d  = nx;
          cy_d  = ny;
          if (nd == DEPTH_LAST) begin
            res_d.index = lin_index(nd, nx, ny);
            res_d.depth = nd;
            res_d.x     = nx;
            res_d.y     = ny;
          end else begin
            rd_en   = 1'b1;
            rd_addr = lin_index(nd, nx, ny);
          end
        end
      end
      ST_MRD: begin
        rd_en   = 1'b1;
        rd_addr = lin_index(nd, {cx_q[CRD_W-2:0], 1'b0}, {cy_q[CRD_W-2:0], 1'b0});
        cc_d    = '0;
      end
      ST_MCHK: begin
        if (cc_q == 2'd0) begin
          v1_d = rd_data;
        end
        if (!chk_fail && cc_q != 2'd3) begin
          cc_d    = cc_q + 2'd1;
          rd_en   = 1'b1;
          rd_addr = lin_index(nd, {cx_q[CRD_W-2:0], cc_d[0]}, {cy_q[CRD_W-2:0], cc_d[1]});
        end
        wc_d = '0;
      end
      ST_MWR: begin
        wr_en = 1'b1;
        if (wc_q == 3'd0) begin
          wr_addr = lin_index(dep_q, cx_q, cy_q);
          wr_data = v1_q;
        end else begin
          wr_addr = lin_index(nd, {cx_q[CRD_W-2:0], wchild[0]},
                              {cy_q[CRD_W-2:0], wchild[1]});
          wr_data = SPLIT_MARK;
        end
        wc_d = wc_q + 3'd1;
      end
      default: ;
    endcase
    // step to the next parent after a failed check or a finished write-back
    if ((state_q == ST_MCHK && chk_fail) || (state_q == ST_MWR && wc_q == 3'd4)) begin
      if (cx_q != side_last) begin
        cx_d = cx_q + CRD_W'(1);
      end else begin
        cx_d = '0;
        if (cy_q != side_last) begin
          cy_d = cy_q + CRD_W'(1);
        end else begin
          cy_d = '0;
          if (dep_q != '0) begin
            dep_d = dep_q - DEP_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dirty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    val_q <= val_d;
    v1_q  <= v1_d;
    px_q  <= px_d;
    py_q  <= py_d;
    dep_q <= dep_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    cc_q  <= cc_d;
    wc_q  <= wc_d;
    res_q <= res_d;
  end

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en)) else $error("node store read and write in one cycle");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_addr < IDX_W'(NODE_COUNT))) else $error("node write out of range");

  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dirty_q |=> dirty_q) else $error("dirty flag cleared");

  a_merge_keeps_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MWR) |=> $stable(dirty_q)) else $error("merge changed dirty flag");

endmodule

// File: sv/linear_quadtree_merge_and_locate.sv
// top level: quadtree node store with merge sweep, point locate and output register
//
// input channel: in_valid_i / in_stall_o carry one word per action (write node,
// merge pass, locate pixel); output channel: out_valid_o / out_stall_i carry
// exactly one result word per input word, in order.
// a word is taken while the sequencer is idle; in_stall_o is high while an
// action is in progress or its result cannot yet leave the sequencer.
// steps for each word:
// write: read old value from the node store, compare and write back, hand over.
// locate: a pixel outside the image goes straight to the result, else one node
// store read per tree level walked.
// merge: each internal node's children are read one at a time through the single
// read port of the node store; an unused action code goes straight to the result.
// the result reaches the outputs in the same cycle as the next word can be taken;
// the output register holds a finished result while the next word is taken;
// when out_stall_i is high the result stays and the sequencer waits once done.
// reset clears the dirty flag and the control state; the node store is not
// cleared and must be written before it is read.
module linear_quadtree_merge_and_locate (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lqml_pkg::ACT_W-1:0] action_i,
  input  logic [lqml_pkg::IDX_W-1:0] node_index_i,
  input  logic signed [lqml_pkg::VAL_W-1:0] node_value_i,
  input  logic [lqml_pkg::PIX_W-1:0] pixel_x_i,
  input  logic [lqml_pkg::PIX_W-1:0] pixel_y_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lqml_pkg::IDX_W-1:0] leaf_index_o,
  output logic [lqml_pkg::DEP_W-1:0] leaf_depth_o,
  output logic [lqml_pkg::CRD_W-1:0] leaf_x_o,
  output logic [lqml_pkg::CRD_W-1:0] leaf_y_o,
  output logic                       tree_dirty_o
);
  import lqml_pkg::*;

  logic    res_valid, res_ready;
  result_t res;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  lqml_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .node_index_i(node_index_i),
    .node_value_i(VAL_W'(node_value_i)),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res_valid;
      if (res_valid) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign leaf_index_o = out_q.index;
  assign leaf_depth_o = out_q.depth;
  assign leaf_x_o     = out_q.x;
  assign leaf_y_o     = out_q.y;
  assign tree_dirty_o = out_q.dirty;

endmodule

// File: bench/tb_linear_quadtree_merge_and_locate.sv
// testbench for the quadtree merge and locate block: random and directed words against a predictor
`timescale 1ns / 100ps

module tb_linear_quadtree_merge_and_locate;
  import lqml_pkg::*;

  typedef struct {
    action_e                act;
    logic [IDX_W-1:0]       idx;
    logic signed [VAL_W-1:0] val;
    logic [PIX_W-1:0]       px;
    logic [PIX_W-1:0]       py;
  } quad_cmd_t;

  class tree_scoreboard;
    logic [VAL_W-1:0] nodes [NODE_COUNT];
    logic             dirty;
    result_t          pending [$];

    function new();
      dirty = 1'b0;
      foreach (nodes[i]) nodes[i] = '0;
    endfunction

    function int slot(int d, int x, int y);
      return ((1 << (2 * d)) - 1) / 3 + (y << d) + x;
    endfunction

    function void sweep();
      int c, a, b, e, f;
      for (int d = LEVEL_LIMIT - 1; d >= 0; d--)
        for (int y = 0; y < (1 << d); y++)
          for (int x = 0; x < (1 << d); x++) begin
            a = slot(d + 1, 2 * x, 2 * y);
            b = slot(d + 1, 2 * x + 1, 2 * y);
            e = slot(d + 1, 2 * x, 2 * y + 1);
            f = slot(d + 1, 2 * x + 1, 2 * y + 1);
            if (nodes[a] != SPLIT_MARK && nodes[b] == nodes[a] && nodes[e] == nodes[a] &&
                nodes[f] == nodes[a]) begin
              c = slot(d, x, y);
              nodes[c] = nodes[a];
              nodes[a] = SPLIT_MARK;
              nodes[b] = SPLIT_MARK;
              nodes[e] = SPLIT_MARK;
              nodes[f] = SPLIT_MARK;
            end
          end
    endfunction

    function void note(quad_cmd_t w);
      result_t r;
      int d, x, y, sw, sh;
      r = '0;
      if (w.act == ACT_WRITE) begin
        if (int'(w.idx) < NODE_COUNT && nodes[w.idx] != w.val) begin
          nodes[w.idx] = w.val;
          dirty = 1'b1;
        end
      end else if (w.act == ACT_MERGE) begin
        sweep();
      end else if (w.act == ACT_LOCATE && int'(w.px) < IMAGE_WIDTH &&
                   int'(w.py) < IMAGE_HEIGHT) begin
        d = 0; x = 0; y = 0;
        while (d < LEVEL_LIMIT && nodes[slot(d, x, y)] == SPLIT_MARK) begin
          sw = IMAGE_WIDTH >> d;
          sh = IMAGE_HEIGHT >> d;
          x = x * 2 + ((int'(w.px) >= x * sw + sw / 2) ? 1 : 0);
          y = y * 2 + ((int'(w.py) >= y * sh + sh / 2) ? 1 : 0);
          d++;
        end
        r.index = IDX_W'(slot(d, x, y));
        r.depth = DEP_W'(d);
        r.x     = CRD_W'(x);
        r.y     = CRD_W'(y);
      end
      r.dirty = dirty;
      pending.push_back(r);
    endfunction

    function int check(result_t got, output result_t want);
      want = '0;
      if (pending.size() == 0) return 1;
      want = pending.pop_front();
      return (got == want) ? 0 : 2;
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [ACT_W-1:0]        action_i = '0;
  logic [IDX_W-1:0]        node_index_i = '0;
  logic signed [VAL_W-1:0] node_value_i = '0;
  logic [PIX_W-1:0]        pixel_x_i = '0;
  logic [PIX_W-1:0]        pixel_y_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [IDX_W-1:0]        leaf_index_o;
  logic [DEP_W-1:0]        leaf_depth_o;
  logic [CRD_W-1:0]        leaf_x_o;
  logic [CRD_W-1:0]        leaf_y_o;
  logic                    tree_dirty_o;

  tree_scoreboard tree_sb = new();
  int  fail_count = 0;
  int  word_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;

  linear_quadtree_merge_and_locate DUT (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // results are sampled at the falling edge, where outputs and stall are settled
  always @(negedge clk_i) begin
    result_t got, want;
    int      verdict;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{leaf_index_o, leaf_depth_o, leaf_x_o, leaf_y_o, tree_dirty_o};
      verdict = tree_sb.check(got, want);
      if (verdict == 1) report("result word with none expected");
      else if (verdict == 2) begin
        if (got.index != want.index)
          report($sformatf("leaf_index %0d, want %0d", got.index, want.index));
        if (got.depth != want.depth)
          report($sformatf("leaf_depth %0d, want %0d", got.depth, want.depth));
        if (got.x != want.x) report($sformatf("leaf_x %0d, want %0d", got.x, want.x));
        if (got.y != want.y) report($sformatf("leaf_y %0d, want %0d", got.y, want.y));
        if (got.dirty != want.dirty)
          report($sformatf("tree_dirty %0b, want %0b", got.dirty, want.dirty));
      end
    end
  end

  task automatic send(action_e act, int idx, int val, int px, int py);
    quad_cmd_t w;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    w.act = act;
    w.idx = IDX_W'(idx);
    w.val = VAL_W'(val);
    w.px  = PIX_W'(px);
    w.py  = PIX_W'(py);
    in_valid_i   <= 1'b1;
    action_i     <= act;
    node_index_i <= w.idx;
    node_value_i <= w.val;
    pixel_x_i    <= w.px;
    pixel_y_i    <= w.py;
    do @(negedge clk_i); while (in_stall_o);
    tree_sb.note(w);
    word_count++;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tree_sb.pending.size() != 0);
    repeat (LEVEL_LIMIT + 4) @(posedge clk_i);
  endtask

  function automatic int pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return -1;
    if (r < 70) return $urandom_range(0, 3);
    return $urandom_range(0, 255);
  endfunction

  task automatic write_node(int idx, int val);
    send(ACT_WRITE, idx, val, $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic locate_at(int px, int py);
    send(ACT_LOCATE, $urandom_range(0, 511), $urandom_range(0, 511) - 256, px, py);
  endtask

  task automatic merge_tree();
    send(ACT_MERGE, $urandom_range(0, 511), $urandom_range(0, 511) - 256,
         $urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  task automatic random_word();
    int r, d, x, y, v, base;
    r = $urandom_range(0, 99);
    if (r < 7) merge_tree();
    else if (r < 10)
      send(ACT_NONE, $urandom_range(0, 511), $urandom_range(0, 511) - 256,
           $urandom_range(0, 4095), $urandom_range(0, 4095));
    else if (r < 40) begin
      if ($urandom_range(0, 9) == 0) write_node($urandom_range(NODE_COUNT, 511), pick_value());
      else write_node($urandom_range(0, NODE_COUNT - 1), pick_value());
    end else if (r < 55) begin
      // four equal siblings, often followed by a merge
      d = $urandom_range(0, LEVEL_LIMIT - 1);
      x = $urandom_range(0, (1 << d) - 1);
      y = $urandom_range(0, (1 << d) - 1);
      v = $urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3);
      base = ((1 << (2 * (d + 1))) - 1) / 3;
      write_node(base + ((2 * y) << (d + 1)) + 2 * x, v);
      write_node(base + ((2 * y) << (d + 1)) + 2 * x + 1, v);
      write_node(base + ((2 * y + 1) << (d + 1)) + 2 * x, v);
      write_node(base + ((2 * y + 1) << (d + 1)) + 2 * x + 1, v);
      if ($urandom_range(0, 1)) merge_tree();
    end else if (r < 65) begin
      d = $urandom_range(0, LEVEL_LIMIT - 1);
      write_node(((1 << (2 * d)) - 1) / 3 + $urandom_range(0, (1 << (2 * d)) - 1), -1);
    end else if ($urandom_range(0, 9) == 0)
      locate_at($urandom_range(0, 4095), $urandom_range(0, 4095));
    else
      locate_at($urandom_range(0, IMAGE_WIDTH - 1), $urandom_range(0, IMAGE_HEIGHT - 1));
  endtask

  initial begin
    #100ms;
    $display("tb_linear_quadtree_merge_and_locate failed");
    $finish;
  end

  initial begin
    int target;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // every node gets a value before a locate or merge reads the store
    for (int i = 0; i < NODE_COUNT; i++) write_node(i, (i == 0) ? -1 : (i % 4));
    write_node(0, 255);
    locate_at(0, 0);
    write_node(0, -1);
    write_node(1, -1);
    write_node(5, -1);
    write_node(21, -1);
    locate_at(0, 0);
    locate_at(IMAGE_WIDTH - 1, IMAGE_HEIGHT - 1);
    locate_at(IMAGE_WIDTH, 0);
    locate_at(0, IMAGE_HEIGHT);
    locate_at(4095, 4095);
    write_node(511, 255);
    write_node(NODE_COUNT, 0);
    write_node(340, 255);
    write_node(340, 255);
    send(ACT_NONE, 511, -1, 4095, 4095);
    for (int i = 85; i < 89; i++) write_node(i, 7);
    merge_tree();
    locate_at(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
    merge_tree();
    locate_at(IMAGE_WIDTH / 2 - 1, IMAGE_HEIGHT / 2 - 1);
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 53 : 19) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 53 : 19) : 0;
      target = word_count + 280;
      while (word_count < target) random_word();
      drain();
    end
    in_valid_i <= 1'b0;
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) $display("tb_linear_quadtree_merge_and_locate passed");
    else $display("tb_linear_quadtree_merge_and_locate failed");
    $finish;
  end

endmodule
